// ===== hw/rtl/nmp_pkg.sv =====
// ---------------------------------------------------------------------------
// nmp_pkg
// Shared types, constants and the elaboration-time sine table builder for the
// NCO mixer with PLL update.
// ---------------------------------------------------------------------------
`default_nettype none

package nmp_pkg;

    // What one item asks the block to do
    typedef enum logic [1:0] {
        ACT_MIX_UP   = 2'd0,
        ACT_MIX_DOWN = 2'd1,
        ACT_PLL      = 2'd2,
        ACT_READ     = 2'd3
    } action_t;

    // Register map, word index on the APB port
    typedef enum logic [1:0] {
        REG_START_FREQ  = 2'd0,
        REG_START_PHASE = 2'd1,
        REG_PLL_ALPHA   = 2'd2,
        REG_PLL_BETA    = 2'd3
    } reg_idx_t;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ERR_W     = 32;
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;
    // signed error times gain with a zero sign bit added
    localparam int PROD_W    = ERR_W + GAIN_W + 1;
    localparam int DELTA_W   = PROD_W - GAIN_FRAC;

    localparam logic [GAIN_W-1:0] ALPHA_RESET = GAIN_W'(6554);
    localparam logic [GAIN_W-1:0] BETA_RESET  = GAIN_W'(20724);

    // pi/2 in Q30 and the Taylor series divisors (2n)(2n+1)
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam int unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    // sin(pi/2 * k / Q), Q = 2^(tb-2), rounded half up to Q1.(sb-1)
    function automatic int quarter_sine(int unsigned k, int tb, int sb);
        longint unsigned x;
        longint unsigned t;
        longint          sum;
        longint          hi;
        int              sh;
        int              n;
        x   = (longint'(k) * HALFPI_Q30) >> (tb - 2);
        t   = x;
        sum = longint'(x);
        for (n = 1; n <= 8; n++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[n - 1];
            if (n[0])
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        sh  = 30 - (sb - 1);
        sum = (sum + (longint'(1) << (sh - 1))) >>> sh;
        hi  = (longint'(1) << (sb - 1)) - 1;
        if (sum > hi)
            sum = hi;
        if (sum < -hi - 1)
            sum = -hi - 1;
        return int'(sum);
    endfunction

    // Full-wave entry built from the quarter wave by mirroring and negation
    function automatic int rom_entry(int unsigned i, int tb, int sb);
        int unsigned q;
        int unsigned quad;
        int unsigned r;
        int          v;
        q    = 1 << (tb - 2);
        quad = i >> (tb - 2);
        r    = i & (q - 1);
        v    = quad[0] ? quarter_sine(q - r, tb, sb) : quarter_sine(r, tb, sb);
        return quad[1] ? -v : v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nco_mixer_with_pll_top.sv =====
// ---------------------------------------------------------------------------
// nco_mixer_with_pll_top
// Numerically controlled oscillator with complex mixer and PLL update.
// ---------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low and returns one
// result per item, in order. Items pass through six registered stages:
// input, PLL gain products, phase/frequency state update, sine table read,
// mixer products and rounding into the output register. The phase and
// frequency state is read and written in a single stage with one add (and a
// saturating add for the frequency), which is what lets every item follow
// the previous one with no gap. Each stage holds its item only while the
// stage after it is full and stalled, so empty stages keep taking items
// while a result waits.
// Register writes on the APB port are meant for when no item is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module nco_mixer_with_pll_top #(
    parameter int TABLE_BITS  = 8,
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nmp_pkg::ADDR_W-1:0]           paddr,
    input  logic [nmp_pkg::DATA_W-1:0]           pwdata,
    output logic [nmp_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           action,
    input  logic signed [SAMPLE_BITS-1:0]        sample_i,
    input  logic signed [SAMPLE_BITS-1:0]        sample_q,
    input  logic signed [nmp_pkg::ERR_W-1:0]     phase_error,
    // result items
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        out_i,
    output logic signed [SAMPLE_BITS-1:0]        out_q,
    output logic signed [31:0]                   phase_now,
    output logic signed [31:0]                   frequency_now
);

    localparam int PB      = PHASE_BITS;
    localparam int SB      = SAMPLE_BITS;
    localparam int PROD_W  = nmp_pkg::PROD_W;
    localparam int DELTA_W = nmp_pkg::DELTA_W;
    localparam int SUM_W   = ((PB > DELTA_W) ? PB : DELTA_W) + 1;
    localparam int CFG_W   = (PB > nmp_pkg::DATA_W) ? PB : nmp_pkg::DATA_W;
    localparam int MUL_W   = 2 * SB;
    localparam int MIX_W   = 2 * SB + 2;

    localparam logic signed [PROD_W-1:0] GAIN_ROUND =
        PROD_W'(longint'(1) << (nmp_pkg::GAIN_FRAC - 1));
    localparam logic signed [SUM_W-1:0]  FSUM_MAX = SUM_W'((longint'(1) << (PB - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  FSUM_MIN = ~FSUM_MAX;
    localparam logic signed [CFG_W-1:0]  FCFG_MAX = CFG_W'((longint'(1) << (PB - 1)) - 1);
    localparam logic signed [CFG_W-1:0]  FCFG_MIN = ~FCFG_MAX;
    localparam logic signed [MIX_W-1:0]  MIX_ROUND = MIX_W'(longint'(1) << (SB - 2));
    localparam logic signed [MIX_W-1:0]  SMP_MAX  = MIX_W'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [MIX_W-1:0]  SMP_MIN  = ~SMP_MAX;

    // ------------------------------------------------------------------
    // Registers and state
    // ------------------------------------------------------------------
    logic [nmp_pkg::DATA_W-1:0]  start_freq_reg;
    logic [nmp_pkg::DATA_W-1:0]  start_phase_reg;
    logic [nmp_pkg::GAIN_W-1:0]  alpha_reg;
    logic [nmp_pkg::GAIN_W-1:0]  beta_reg;
    logic        [PB-1:0]        phase_acc_reg;
    logic        [PB-1:0]        phase_acc_next;
    logic signed [PB-1:0]        freq_acc_reg;
    logic signed [PB-1:0]        freq_acc_next;

    // pipeline valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic take1, take2, take3, take4, take5, take6;

    // stage payloads
    nmp_pkg::action_t                s1_action_reg, s2_action_reg, s3_action_reg;
    nmp_pkg::action_t                s4_action_reg, s5_action_reg;
    logic signed [SB-1:0]            s1_xi_reg, s1_xq_reg, s2_xi_reg, s2_xq_reg;
    logic signed [SB-1:0]            s3_xi_reg, s3_xq_reg, s4_xi_reg, s4_xq_reg;
    logic signed [nmp_pkg::ERR_W-1:0] s1_err_reg;
    logic signed [PROD_W-1:0]        s2_prod_a_reg, s2_prod_b_reg;
    logic        [PB-1:0]            s3_lookup_reg;
    logic signed [31:0]              s3_phase_now_reg, s4_phase_now_reg, s5_phase_now_reg;
    logic signed [31:0]              s3_freq_now_reg, s4_freq_now_reg, s5_freq_now_reg;
    logic signed [SB-1:0]            s4_cos_reg, s4_sin_reg, s5_cos_reg, s5_sin_reg;
    logic signed [MUL_W-1:0]         s5_ic_reg, s5_qs_reg, s5_is_reg, s5_qc_reg;
    logic signed [SB-1:0]            out_i_reg, out_q_reg;
    logic signed [31:0]              phase_now_reg, frequency_now_reg;

    // combinational
    logic                            cfg_we;
    nmp_pkg::reg_idx_t               cfg_idx;
    logic signed [CFG_W-1:0]         cfg_freq_wide;
    logic signed [PB-1:0]            cfg_freq_sat;
    logic signed [PROD_W-1:0]        prod_alpha, prod_beta;
    logic signed [DELTA_W-1:0]       delta_f, delta_p;
    logic signed [SUM_W-1:0]         freq_sum, dp_ext;
    logic signed [PB-1:0]            freq_pll;
    logic        [PB-1:0]            phase_upd, lookup_phase;
    logic signed [PB-1:0]            freq_upd;
    logic                            step_fire;
    logic signed [SB-1:0]            rom_cos, rom_sin;
    logic signed [MIX_W-1:0]         mix_i, mix_q, rnd_i, rnd_q;
    logic signed [SB-1:0]            sat_i, sat_q, res_i, res_q;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = nmp_pkg::reg_idx_t'(paddr[nmp_pkg::ADDR_W-1:2]);

    always_comb
    begin
        unique case (cfg_idx)
            nmp_pkg::REG_START_FREQ:  prdata = start_freq_reg;
            nmp_pkg::REG_START_PHASE: prdata = start_phase_reg;
            nmp_pkg::REG_PLL_ALPHA:   prdata = nmp_pkg::DATA_W'(alpha_reg);
            nmp_pkg::REG_PLL_BETA:    prdata = nmp_pkg::DATA_W'(beta_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_freq_reg  <= '0;
            start_phase_reg <= '0;
            alpha_reg       <= nmp_pkg::ALPHA_RESET;
            beta_reg        <= nmp_pkg::BETA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                nmp_pkg::REG_START_FREQ:  start_freq_reg  <= pwdata;
                nmp_pkg::REG_START_PHASE: start_phase_reg <= pwdata;
                nmp_pkg::REG_PLL_ALPHA:   alpha_reg       <= pwdata[nmp_pkg::GAIN_W-1:0];
                nmp_pkg::REG_PLL_BETA:    beta_reg        <= pwdata[nmp_pkg::GAIN_W-1:0];
                default:                  ;
            endcase
        end
    end

    // start frequency saturated into the accumulator width
    always_comb
    begin
        cfg_freq_wide = CFG_W'($signed(pwdata));
        if (cfg_freq_wide > FCFG_MAX)
            cfg_freq_sat = PB'(FCFG_MAX);
        else if (cfg_freq_wide < FCFG_MIN)
            cfg_freq_sat = PB'(FCFG_MIN);
        else
            cfg_freq_sat = PB'(cfg_freq_wide);
    end

    // ------------------------------------------------------------------
    // Flow control: a stage takes a new item when empty or when moving on
    // ------------------------------------------------------------------
    assign take6    = !out_valid_reg || !out_stall;
    assign take5    = !s5_valid_reg || take6;
    assign take4    = !s4_valid_reg || take5;
    assign take3    = !s3_valid_reg || take4;
    assign take2    = !s2_valid_reg || take3;
    assign take1    = !s1_valid_reg || take2;
    assign in_stall = !take1;
    assign step_fire = s2_valid_reg && take3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                s1_valid_reg <= in_valid;
            if (take2)
                s2_valid_reg <= s1_valid_reg;
            if (take3)
                s3_valid_reg <= s2_valid_reg;
            if (take4)
                s4_valid_reg <= s3_valid_reg;
            if (take5)
                s5_valid_reg <= s4_valid_reg;
            if (take6)
                out_valid_reg <= s5_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            s1_action_reg <= nmp_pkg::action_t'(action);
            s1_xi_reg     <= sample_i;
            s1_xq_reg     <= sample_q;
            s1_err_reg    <= phase_error;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: loop gain products
    // ------------------------------------------------------------------
    assign prod_alpha = PROD_W'(s1_err_reg) * PROD_W'($signed({1'b0, alpha_reg}));
    assign prod_beta  = PROD_W'(s1_err_reg) * PROD_W'($signed({1'b0, beta_reg}));

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            s2_action_reg <= s1_action_reg;
            s2_xi_reg     <= s1_xi_reg;
            s2_xq_reg     <= s1_xq_reg;
            s2_prod_a_reg <= prod_alpha;
            s2_prod_b_reg <= prod_beta;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: phase and frequency update
    // ------------------------------------------------------------------
    assign delta_f = DELTA_W'((s2_prod_a_reg + GAIN_ROUND) >>> nmp_pkg::GAIN_FRAC);
    assign delta_p = DELTA_W'((s2_prod_b_reg + GAIN_ROUND) >>> nmp_pkg::GAIN_FRAC);
    assign freq_sum = SUM_W'(freq_acc_reg) + SUM_W'(delta_f);
    assign dp_ext   = SUM_W'(delta_p);

    // saturating frequency step
    always_comb
    begin
        if (freq_sum > FSUM_MAX)
            freq_pll = PB'(FSUM_MAX);
        else if (freq_sum < FSUM_MIN)
            freq_pll = PB'(FSUM_MIN);
        else
            freq_pll = PB'(freq_sum);
    end

    // per action: new state and the phase the oscillator is read at
    always_comb
    begin
        case (s2_action_reg) inside
            nmp_pkg::ACT_MIX_UP, nmp_pkg::ACT_MIX_DOWN:
            begin
                phase_upd    = phase_acc_reg + $unsigned(freq_acc_reg);
                freq_upd     = freq_acc_reg;
                lookup_phase = phase_acc_reg;
            end
            nmp_pkg::ACT_PLL:
            begin
                phase_upd    = phase_acc_reg + $unsigned(dp_ext[PB-1:0]);
                freq_upd     = freq_pll;
                lookup_phase = phase_upd;
            end
            default:
            begin
                phase_upd    = phase_acc_reg;
                freq_upd     = freq_acc_reg;
                lookup_phase = phase_acc_reg;
            end
        endcase
    end

    // state: register writes load, items step
    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        freq_acc_next  = freq_acc_reg;
        if (cfg_we && cfg_idx == nmp_pkg::REG_START_FREQ)
            freq_acc_next = cfg_freq_sat;
        else if (cfg_we && cfg_idx == nmp_pkg::REG_START_PHASE)
            phase_acc_next = PB'($signed(pwdata));
        else if (step_fire)
        begin
            phase_acc_next = phase_upd;
            freq_acc_next  = freq_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            freq_acc_reg  <= '0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
            freq_acc_reg  <= freq_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            s3_action_reg    <= s2_action_reg;
            s3_xi_reg        <= s2_xi_reg;
            s3_xq_reg        <= s2_xq_reg;
            s3_lookup_reg    <= lookup_phase;
            s3_phase_now_reg <= 32'($signed(phase_upd));
            s3_freq_now_reg  <= 32'(freq_upd);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sine table read
    // ------------------------------------------------------------------
    nmp_sincos_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .phase   (s3_lookup_reg),
        .cos_val (rom_cos),
        .sin_val (rom_sin)
    );

    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            s4_action_reg    <= s3_action_reg;
            s4_xi_reg        <= s3_xi_reg;
            s4_xq_reg        <= s3_xq_reg;
            s4_cos_reg       <= rom_cos;
            s4_sin_reg       <= rom_sin;
            s4_phase_now_reg <= s3_phase_now_reg;
            s4_freq_now_reg  <= s3_freq_now_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: mixer products
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take5)
        begin
            s5_action_reg    <= s4_action_reg;
            s5_ic_reg        <= MUL_W'(s4_xi_reg) * MUL_W'(s4_cos_reg);
            s5_qs_reg        <= MUL_W'(s4_xq_reg) * MUL_W'(s4_sin_reg);
            s5_is_reg        <= MUL_W'(s4_xi_reg) * MUL_W'(s4_sin_reg);
            s5_qc_reg        <= MUL_W'(s4_xq_reg) * MUL_W'(s4_cos_reg);
            s5_cos_reg       <= s4_cos_reg;
            s5_sin_reg       <= s4_sin_reg;
            s5_phase_now_reg <= s4_phase_now_reg;
            s5_freq_now_reg  <= s4_freq_now_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sums, rounding, saturation into the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s5_action_reg == nmp_pkg::ACT_MIX_UP)
        begin
            mix_i = MIX_W'(s5_ic_reg) - MIX_W'(s5_qs_reg);
            mix_q = MIX_W'(s5_is_reg) + MIX_W'(s5_qc_reg);
        end
        else
        begin
            mix_i = MIX_W'(s5_ic_reg) + MIX_W'(s5_qs_reg);
            mix_q = MIX_W'(s5_qc_reg) - MIX_W'(s5_is_reg);
        end
        rnd_i = (mix_i + MIX_ROUND) >>> (SB - 1);
        rnd_q = (mix_q + MIX_ROUND) >>> (SB - 1);

        if (rnd_i > SMP_MAX)
            sat_i = SB'(SMP_MAX);
        else if (rnd_i < SMP_MIN)
            sat_i = SB'(SMP_MIN);
        else
            sat_i = SB'(rnd_i);

        if (rnd_q > SMP_MAX)
            sat_q = SB'(SMP_MAX);
        else if (rnd_q < SMP_MIN)
            sat_q = SB'(SMP_MIN);
        else
            sat_q = SB'(rnd_q);

        // loop update and read return the oscillator itself
        case (s5_action_reg) inside
            nmp_pkg::ACT_MIX_UP, nmp_pkg::ACT_MIX_DOWN:
            begin
                res_i = sat_i;
                res_q = sat_q;
            end
            default:
            begin
                res_i = s5_cos_reg;
                res_q = s5_sin_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take6)
        begin
            out_i_reg         <= res_i;
            out_q_reg         <= res_q;
            phase_now_reg     <= s5_phase_now_reg;
            frequency_now_reg <= s5_freq_now_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_i         = out_i_reg;
    assign out_q         = out_q_reg;
    assign phase_now     = phase_now_reg;
    assign frequency_now = frequency_now_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input is only held back when the first stage is occupied
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall raised with an empty input stage");

    // state moves only on an item passing the update stage or a write
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!step_fire && !cfg_we) |=> ($stable(phase_acc_reg) && $stable(freq_acc_reg)))
        else $error("oscillator state changed with no item or write");

    // apart from a register write, only a loop update may change the frequency
    a_freq_only_pll: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && !cfg_we && s2_action_reg != nmp_pkg::ACT_PLL) |=>
            $stable(freq_acc_reg))
        else $error("frequency changed by a mix or read item");

endmodule

`default_nettype wire

// ===== hw/rtl/nmp_sincos_rom.sv =====
// ---------------------------------------------------------------------------
// nmp_sincos_rom
// Constant sine table; rounds a phase to the table index and returns the
// sine there and the cosine a quarter table further on. Purely combinational.
// ---------------------------------------------------------------------------
`default_nettype none

module nmp_sincos_rom #(
    parameter int TABLE_BITS  = 8,
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        [PHASE_BITS-1:0]  phase,
    output logic signed [SAMPLE_BITS-1:0] cos_val,
    output logic signed [SAMPLE_BITS-1:0] sin_val
);

    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int QTR   = 1 << (TABLE_BITS - 2);
    localparam logic [PHASE_BITS-1:0] ROUND_HALF =
        PHASE_BITS'(1) << (PHASE_BITS - TABLE_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] sine_rom [TSIZE];
    logic        [PHASE_BITS-1:0]  phase_rnd;
    logic        [TABLE_BITS-1:0]  sin_idx;
    logic        [TABLE_BITS-1:0]  cos_idx;

    // table contents fixed at elaboration
    for (genvar g = 0; g < TSIZE; g++)
    begin : g_rom
        assign sine_rom[g] = SAMPLE_BITS'(nmp_pkg::rom_entry(g, TABLE_BITS, SAMPLE_BITS));
    end

    // round half up to the top TABLE_BITS of the phase, wrapping
    assign phase_rnd = phase + ROUND_HALF;
    assign sin_idx   = phase_rnd[PHASE_BITS-1 -: TABLE_BITS];
    assign cos_idx   = sin_idx + TABLE_BITS'(QTR);

    assign sin_val = sine_rom[sin_idx];
    assign cos_val = sine_rom[cos_idx];

endmodule

`default_nettype wire
